/* rtl/mhjs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhjs_pkg: shared types and constants
// Widths, heap entry layout and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package mhjs_pkg;

  localparam int MAX_WORKERS = 256;
  localparam int IDX_W       = $clog2(MAX_WORKERS);
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int CFG_W       = 9;
  localparam int DUR_W       = 32;
  localparam int TIME_W      = 64;
  localparam int WID_W       = 8;
  localparam int ENT_W       = TIME_W + IDX_W;

  typedef struct packed {
    logic [TIME_W-1:0] free_time;
    logic [IDX_W-1:0]  worker_id;
  } ent_t;

  typedef struct packed {
    logic accept;
    logic rd_root;
    logic load_root;
    logic sift_rd;
    logic sift_cmp;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic has_child;
    logic sink_done;
  } status_t;

endpackage
`default_nettype wire

/* rtl/mhjs_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhjs_in_if: job channel
// Carries one job per beat: batch restart flag and duration.
// ----------------------------------------------------------------------------
interface mhjs_in_if;
  import mhjs_pkg::*;

  logic             valid;
  logic             ready;
  logic             new_batch;
  logic [DUR_W-1:0] job_duration;

  modport source (output valid, output new_batch, output job_duration, input ready);
  modport sink   (input valid, input new_batch, input job_duration, output ready);

endinterface
`default_nettype wire

/* rtl/mhjs_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhjs_out_if: assignment channel
// Carries one assignment per beat: worker number and start time.
// ----------------------------------------------------------------------------
interface mhjs_out_if;
  import mhjs_pkg::*;

  logic              valid;
  logic              ready;
  logic [WID_W-1:0]  worker;
  logic [TIME_W-1:0] start_time;

  modport source (output valid, output worker, output start_time, input ready);
  modport sink   (input valid, input worker, input start_time, output ready);

endinterface
`default_nettype wire

/* rtl/mhjs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhjs_ram: generic ram
// One write port, two read ports sharing a read enable, registered read data.
// ----------------------------------------------------------------------------
module mhjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

/* rtl/mhjs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhjs_ctrl: scheduler controller
// Sequences job accept, root read, result hand-off and the sift-down walk.
// ----------------------------------------------------------------------------
module mhjs_ctrl import mhjs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT_RD,
    S_ROOT_WAIT,
    S_SIFT_RD,
    S_SIFT_CMP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.accept = 1'b1;
          state_nxt  = S_ROOT_RD;
        end
      end
      S_ROOT_RD: begin
        cmd.rd_root = 1'b1;
        state_nxt   = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (status.out_free) begin
          cmd.load_root = 1'b1;
          state_nxt     = S_SIFT_RD;
        end
      end
      S_SIFT_RD: begin
        cmd.sift_rd = 1'b1;
        state_nxt   = status.has_child ? S_SIFT_CMP : S_IDLE;
      end
      S_SIFT_CMP: begin
        cmd.sift_cmp = 1'b1;
        state_nxt    = status.sink_done ? S_IDLE : S_SIFT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule
`default_nettype wire

/* rtl/mhjs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhjs_dp: scheduler datapath
// Heap memory with per-entry valid bits, sinking entry, compare and output.
// ----------------------------------------------------------------------------
module mhjs_dp import mhjs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_new_batch,
  input  wire logic [DUR_W-1:0]  in_job_duration,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [WID_W-1:0]  out_worker,
  output logic      [TIME_W-1:0] out_start_time
);

  localparam int CW = IDX_W + 2;

  logic [CFG_W-1:0]       cfg_cnt_r;
  logic [DUR_W-1:0]       dur_r;
  ent_t                   x_r;
  logic [IDX_W-1:0]       pos_r;
  logic [MAX_WORKERS-1:0] valid_r;
  logic                   rva_r, rvb_r;
  logic [IDX_W-1:0]       raddr_a_r, raddr_b_r;
  logic                   out_valid_r;
  logic [WID_W-1:0]       out_worker_r;
  logic [TIME_W-1:0]      out_time_r;

  logic [CNT_W-1:0] size;
  logic [CW-1:0]    size_w, lc_w, rc_w;
  logic             has_child, rc_ex;
  logic [IDX_W-1:0] raddr_a, raddr_b;
  logic             re, we;
  ent_t             wdata;
  logic [ENT_W-1:0] rdata_a, rdata_b;
  ent_t             ent_a, ent_b, ram_a, ram_b;
  logic             p_lx, p_rx, p_rl, sel_l, sel_r, done;
  logic             out_free;

  always_comb begin
    if (cfg_cnt_r == '0) begin
      size = CNT_W'(1);
    end else if (32'(cfg_cnt_r) > 32'(MAX_WORKERS)) begin
      size = CNT_W'(MAX_WORKERS);
    end else begin
      size = CNT_W'(cfg_cnt_r);
    end
  end

  assign size_w    = CW'(size);
  assign lc_w      = CW'({pos_r, 1'b1});
  assign rc_w      = lc_w + CW'(1);
  assign has_child = lc_w < size_w;
  assign rc_ex     = rc_w < size_w;

  assign raddr_a = cmd.rd_root ? '0 : lc_w[IDX_W-1:0];
  assign raddr_b = rc_w[IDX_W-1:0];
  assign re      = cmd.rd_root || (cmd.sift_rd && has_child);

  assign ram_a = ent_t'(rdata_a);
  assign ram_b = ent_t'(rdata_b);

  // entries not written since the last rebuild read as their rebuilt value
  always_comb begin
    ent_a = rva_r ? ram_a : ent_t'{free_time: '0, worker_id: raddr_a_r};
    ent_b = rvb_r ? ram_b : ent_t'{free_time: '0, worker_id: raddr_b_r};
  end

  function automatic logic precedes(ent_t a, ent_t b);
    if (a.free_time != b.free_time) begin
      return a.free_time < b.free_time;
    end
    return a.worker_id < b.worker_id;
  endfunction

  assign p_lx  = precedes(ent_a, x_r);
  assign p_rx  = precedes(ent_b, x_r);
  assign p_rl  = precedes(ent_b, ent_a);
  assign sel_r = rc_ex && (p_lx ? p_rl : p_rx);
  assign sel_l = p_lx && !sel_r;
  assign done  = !sel_l && !sel_r;

  assign we = (cmd.sift_rd && !has_child) || cmd.sift_cmp;

  always_comb begin
    wdata = x_r;
    if (cmd.sift_cmp && sel_r) begin
      wdata = ent_b;
    end else if (cmd.sift_cmp && sel_l) begin
      wdata = ent_a;
    end
  end

  mhjs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WORKERS)
  ) u_heap_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (pos_r),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cnt_r   <= CFG_W'(1);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_cnt_r <= cfg_wdata;
      end
      if (cmd.accept && in_new_batch) begin
        valid_r <= '0;
      end else if (we) begin
        valid_r[pos_r] <= 1'b1;
      end
      if (cmd.load_root) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dur_r <= in_job_duration;
    end
    if (re) begin
      rva_r     <= valid_r[raddr_a];
      rvb_r     <= valid_r[raddr_b];
      raddr_a_r <= raddr_a;
      raddr_b_r <= raddr_b;
    end
    if (cmd.load_root) begin
      out_worker_r  <= WID_W'(ent_a.worker_id);
      out_time_r    <= ent_a.free_time;
      x_r.free_time <= ent_a.free_time + TIME_W'(dur_r);
      x_r.worker_id <= ent_a.worker_id;
      pos_r         <= '0;
    end else if (cmd.sift_cmp && !done) begin
      pos_r <= sel_r ? raddr_b_r : raddr_a_r;
    end
  end

  assign status.out_free  = out_free;
  assign status.has_child = has_child;
  assign status.sink_done = done;

  assign out_valid      = out_valid_r;
  assign out_worker     = out_worker_r;
  assign out_start_time = out_time_r;

endmodule
`default_nettype wire

/* rtl/min_heap_job_scheduler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_job_scheduler: earliest-free worker assignment
// Jobs arrive on in_ch (new_batch, job_duration); each yields one beat on
// out_ch with the worker that frees up first (lower number on ties) and the
// time it starts the job. cfg_we/cfg_wdata set the worker count (0 counts as
// one, above 256 saturates); write it only while the block is idle.
// An accepted job reads the heap root in state S_ROOT_RD, waits in
// S_ROOT_WAIT until the output register is free, places the result there,
// then sinks the updated root through the heap in the dual-read heap
// memory, a read state (S_SIFT_RD) and a compare state (S_SIFT_CMP) per
// level, writing the entry where it settles; in_ch ready returns only after
// the walk ends.
// Reset sets the count to one and rebuilds the heap at once (all workers
// free at time zero) through per-entry valid bits; new_batch only rebuilds.
// The output register holds one result while out_ch stalls, so the next job
// is still accepted; it waits before its own hand-off until the slot frees.
// ----------------------------------------------------------------------------
module min_heap_job_scheduler import mhjs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  mhjs_in_if.sink               in_ch,
  mhjs_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  mhjs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mhjs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_new_batch    (in_ch.new_batch),
    .in_job_duration (in_ch.job_duration),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_worker      (out_ch.worker),
    .out_start_time  (out_ch.start_time)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire
